### sv/rbc_pkg.sv
// Shared types, codes and constants of the reconnect backoff controller.
package rbc_pkg;

  // Widest delay counter the block can be built with
  localparam int unsigned DELAY_BITS_DEF = 32;

  // Shared multiplier operand widths
  localparam int unsigned MUL_A_W = 32;
  localparam int unsigned MUL_B_W = 17;
  localparam int unsigned MUL_P_W = MUL_A_W + MUL_B_W;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // Configuration reset values
  localparam logic [31:0] INITIAL_BACKOFF_RST = 32'd100;
  localparam logic [31:0] MAX_BACKOFF_RST     = 32'd30000;
  localparam logic [15:0] GROWTH_FACTOR_RST   = 16'd512;
  localparam logic [16:0] JITTER_SPAN_RST     = 17'd13107;
  localparam logic [31:0] STARTUP_LIMIT_RST   = 32'd10000;

  // Jitter fraction of one in Q1.16
  localparam logic [16:0] JITTER_ONE = 17'h10000;

  localparam logic [3:0] FAULT_NONE    = 4'd0;
  localparam logic [3:0] FAULT_TIMEOUT = 4'd15;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INITIAL_BACKOFF = 3'd0,
    CFG_MAX_BACKOFF     = 3'd1,
    CFG_GROWTH_FACTOR   = 3'd2,
    CFG_JITTER_SPAN     = 3'd3,
    CFG_STARTUP_LIMIT   = 3'd4
  } cfg_idx_e;

  typedef enum logic [2:0] {
    OP_START     = 3'd0,
    OP_STOP      = 3'd1,
    OP_TICK      = 3'd2,
    OP_LINK_UP   = 3'd3,
    OP_LINK_DOWN = 3'd4
  } opcode_e;

  typedef enum logic [2:0] {
    PC_STOPPED    = 3'd0,
    PC_CONNECTING = 3'd1,
    PC_READY      = 3'd2,
    PC_RETRYING   = 3'd3,
    PC_STOPPING   = 3'd4
  } phase_code_e;

  typedef enum logic [1:0] {
    CMD_NONE       = 2'd0,
    CMD_CONNECT    = 2'd1,
    CMD_DISCONNECT = 2'd2,
    CMD_BOTH       = 2'd3
  } link_cmd_e;

  typedef struct packed {
    logic [31:0] initial_backoff;
    logic [31:0] max_backoff;
    logic [15:0] growth_factor;
    logic [16:0] jitter_span;
    logic [31:0] startup_limit;
  } cfg_t;

  typedef struct packed {
    phase_code_e phase_code;
    logic [3:0]  fault_code;
    logic [31:0] retry_delay;
    link_cmd_e   link_command;
    logic        last_result;
  } result_t;

  function automatic result_t make_result(input phase_code_e ph, input logic [3:0] fault,
                                          input logic [31:0] delay, input link_cmd_e cmd,
                                          input logic last);
    result_t r;
    r.phase_code   = ph;
    r.fault_code   = fault;
    r.retry_delay  = delay;
    r.link_command = cmd;
    r.last_result  = last;
    return r;
  endfunction

endpackage

### sv/rbc_ifs.sv
// Valid/ready channel interfaces for events in and results out.
interface rbc_in_if;
  logic       valid;
  logic       ready;
  logic [2:0] opcode;
  logic [15:0] random_sample;
  logic [3:0] fault_reason;

  modport source (output valid, output opcode, output random_sample, output fault_reason,
                  input ready);
  modport sink (input valid, input opcode, input random_sample, input fault_reason,
                output ready);
endinterface

interface rbc_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  phase_code;
  logic [3:0]  fault_code;
  logic [31:0] retry_delay;
  logic [1:0]  link_command;
  logic        last_result;

  modport source (output valid, output phase_code, output fault_code, output retry_delay,
                  output link_command, output last_result, input ready);
  modport sink (input valid, input phase_code, input fault_code, input retry_delay,
                input link_command, input last_result, output ready);
endinterface

### sv/rbc_regs.sv
// Configuration register file with write decode and reset values.
module rbc_regs (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [rbc_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [rbc_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  output rbc_pkg::cfg_t                   cfg_o
);
  import rbc_pkg::*;

  cfg_t cfg_q, cfg_d;

  // Decode the register index and update one field
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_INITIAL_BACKOFF: cfg_d.initial_backoff = cfg_data_i;
        CFG_MAX_BACKOFF:     cfg_d.max_backoff     = cfg_data_i;
        CFG_GROWTH_FACTOR:   cfg_d.growth_factor   = cfg_data_i[15:0];
        CFG_JITTER_SPAN:     cfg_d.jitter_span     = cfg_data_i[16:0];
        CFG_STARTUP_LIMIT:   cfg_d.startup_limit   = cfg_data_i;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.initial_backoff <= INITIAL_BACKOFF_RST;
      cfg_q.max_backoff     <= MAX_BACKOFF_RST;
      cfg_q.growth_factor   <= GROWTH_FACTOR_RST;
      cfg_q.jitter_span     <= JITTER_SPAN_RST;
      cfg_q.startup_limit   <= STARTUP_LIMIT_RST;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

### sv/rbc_mul.sv
// Shared unsigned multiplier with a registered product.
module rbc_mul (
  input  logic                          clk_i,
  input  logic                          en_i,
  input  logic [rbc_pkg::MUL_A_W-1:0]   a_i,
  input  logic [rbc_pkg::MUL_B_W-1:0]   b_i,
  output logic [rbc_pkg::MUL_P_W-1:0]   p_o
);
  import rbc_pkg::*;

  logic [MUL_P_W-1:0] p_q;

  // Capture the product on each issued step, hold otherwise
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= MUL_P_W'(a_i) * MUL_P_W'(b_i);
    end
  end

  assign p_o = p_q;

endmodule

### sv/reconnect_backoff_controller.sv
// Reconnect backoff controller: a link supervisor with jittered exponential backoff.
// Each accepted event is decoded in the cycle after its transfer. Start and link up pass
// through accept, decode and loading of the output register, and stop loads its two results
// one after the other; a tick that only counts down, and any event that is ignored, ends at
// decode. A link failure or startup timeout runs three products on one shared 32x17
// multiplier (jitter product, jittered delay, backoff growth) and then a capping step; when
// a timeout's delay comes out as zero, a second result follows.
// Results leave one after the other through the output register; the input stays not
// ready from the accepting transfer until the last result of that event is loaded into
// the output register, so a stalled output sink holds off the next event. Delays saturate
// at 2^DELAY_BITS-1 (at most 2^32-1) and at max_backoff.
module reconnect_backoff_controller #(
  parameter int unsigned DELAY_BITS = rbc_pkg::DELAY_BITS_DEF
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  rbc_in_if.sink                         in_i,
  rbc_out_if.source                      out_o,
  input  logic                           cfg_we_i,
  input  logic [rbc_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [rbc_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import rbc_pkg::*;

  // Retry counter width and saturation limit
  localparam int unsigned RW = (DELAY_BITS < 32) ? DELAY_BITS : 32;
  localparam logic [40:0] LIM = 41'((64'd1 << RW) - 64'd1);

  typedef enum logic [1:0] {
    PH_STOPPED    = 2'd0,
    PH_CONNECTING = 2'd1,
    PH_READY      = 2'd2,
    PH_RETRYING   = 2'd3
  } phase_e;

  typedef enum logic [2:0] {
    S_IDLE = 3'd0,
    S_DEC  = 3'd1,
    S_M1   = 3'd2,
    S_M2   = 3'd3,
    S_M3   = 3'd4,
    S_M4   = 3'd5,
    S_OUT1 = 3'd6,
    S_OUT2 = 3'd7
  } state_e;

  cfg_t cfg;

  logic               mul_en;
  logic [MUL_A_W-1:0] mul_a;
  logic [MUL_B_W-1:0] mul_b;
  logic [MUL_P_W-1:0] mul_p;

  state_e      state_q, state_d;
  phase_e      phase_q, phase_d;
  logic [31:0] backoff_q, backoff_d;
  logic [31:0] sl_q, sl_d;
  logic        armed_q, armed_d;
  logic [RW-1:0] rl_q, rl_d;
  opcode_e     op_q, op_d;
  logic [15:0] r_q, r_d;
  logic [3:0]  reason_q, reason_d;
  logic [3:0]  fault_q, fault_d;
  logic [RW-1:0] delay_q, delay_d;
  result_t     res1_q, res1_d, res2_q, res2_d;
  logic        two_q, two_d;
  result_t     out_q, out_d;
  logic        out_valid_q, out_valid_d;

  logic [16:0] jit;
  logic [17:0] f16;
  logic [31:0] sl_dec;
  logic [RW-1:0] rl_dec;

  rbc_regs u_regs (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .cfg_o      (cfg)
  );

  rbc_mul u_mul (
    .clk_i (clk_i),
    .en_i  (mul_en),
    .a_i   (mul_a),
    .b_i   (mul_b),
    .p_o   (mul_p)
  );

  // Clamp to max_backoff, then saturate to the counter range
  function automatic logic [RW-1:0] cap_delay(input logic [40:0] v, input logic [31:0] mx);
    logic [40:0] m;
    m = (v > {9'b0, mx}) ? {9'b0, mx} : v;
    if (m > LIM) begin
      m = LIM;
    end
    return m[RW-1:0];
  endfunction

  // Jitter fraction clamped to one, and the Q.16 jitter factor
  assign jit = (cfg.jitter_span > JITTER_ONE) ? JITTER_ONE : cfg.jitter_span;
  assign f16 = {1'b0, JITTER_ONE} - {1'b0, jit} + 18'(mul_p[MUL_P_W-1:15]);

  assign sl_dec = (sl_q != '0) ? sl_q - 32'd1 : '0;
  assign rl_dec = (rl_q != '0) ? rl_q - RW'(1) : '0;

  // Sequencer: decode, multiply steps, result hand-off
  always_comb begin
    state_d     = state_q;
    phase_d     = phase_q;
    backoff_d   = backoff_q;
    sl_d        = sl_q;
    armed_d     = armed_q;
    rl_d        = rl_q;
    op_d        = op_q;
    r_d         = r_q;
    reason_d    = reason_q;
    fault_d     = fault_q;
    delay_d     = delay_q;
    res1_d      = res1_q;
    res2_d      = res2_q;
    two_d       = two_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;
    mul_en      = 1'b0;
    mul_a       = '0;
    mul_b       = '0;

    // Drop the held result once its transfer completes
    if (out_valid_q && out_o.ready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (in_i.valid) begin
          op_d     = opcode_e'(in_i.opcode);
          r_d      = in_i.random_sample;
          reason_d = in_i.fault_reason;
          state_d  = S_DEC;
        end
      end

      S_DEC: begin
        state_d = S_IDLE;
        two_d   = 1'b0;
        case (op_q)
          OP_START: begin
            if (phase_q == PH_STOPPED) begin
              backoff_d = cfg.initial_backoff;
              phase_d   = PH_CONNECTING;
              sl_d      = cfg.startup_limit;
              armed_d   = 1'b1;
              rl_d      = '0;
              res1_d    = make_result(PC_CONNECTING, FAULT_NONE, '0, CMD_CONNECT, 1'b1);
              state_d   = S_OUT1;
            end
          end
          OP_STOP: begin
            if (phase_q != PH_STOPPED) begin
              phase_d = PH_STOPPED;
              armed_d = 1'b0;
              sl_d    = '0;
              rl_d    = '0;
              res1_d  = make_result(PC_STOPPING, FAULT_NONE, '0, CMD_DISCONNECT, 1'b0);
              res2_d  = make_result(PC_STOPPED, FAULT_NONE, '0, CMD_NONE, 1'b1);
              two_d   = 1'b1;
              state_d = S_OUT1;
            end
          end
          OP_TICK: begin
            if (phase_q != PH_STOPPED) begin
              if (armed_q) begin
                sl_d = sl_dec;
                if (sl_dec == '0) begin
                  fault_d = FAULT_TIMEOUT;
                  state_d = S_M1;
                end
              end else if (phase_q == PH_RETRYING) begin
                rl_d = rl_dec;
                if (rl_dec == '0) begin
                  phase_d = PH_CONNECTING;
                  sl_d    = cfg.startup_limit;
                  armed_d = 1'b1;
                  res1_d  = make_result(PC_CONNECTING, FAULT_NONE, '0, CMD_BOTH, 1'b1);
                  state_d = S_OUT1;
                end
              end
            end
          end
          OP_LINK_UP: begin
            if (phase_q != PH_STOPPED) begin
              armed_d   = 1'b0;
              sl_d      = '0;
              rl_d      = '0;
              backoff_d = cfg.initial_backoff;
              phase_d   = PH_READY;
              res1_d    = make_result(PC_READY, FAULT_NONE, '0, CMD_NONE, 1'b1);
              state_d   = S_OUT1;
            end
          end
          OP_LINK_DOWN: begin
            if (phase_q != PH_STOPPED && phase_q != PH_RETRYING) begin
              fault_d = reason_q;
              state_d = S_M1;
            end
          end
          default: ;
        endcase
      end

      // Jitter product j*r
      S_M1: begin
        mul_en  = 1'b1;
        mul_a   = MUL_A_W'(jit);
        mul_b   = MUL_B_W'(r_q);
        state_d = S_M2;
      end

      // Jittered delay product
      S_M2: begin
        mul_en  = 1'b1;
        mul_a   = backoff_q;
        mul_b   = f16[16:0];
        state_d = S_M3;
      end

      // Capture the delay, issue the growth product
      S_M3: begin
        delay_d = cap_delay({8'b0, mul_p[MUL_P_W-1:16]}, cfg.max_backoff);
        mul_en  = 1'b1;
        mul_a   = backoff_q;
        mul_b   = MUL_B_W'(cfg.growth_factor);
        state_d = S_M4;
      end

      // Commit the failure, and restart at once on a zero delay after a tick
      S_M4: begin
        backoff_d = 32'(cap_delay(mul_p[MUL_P_W-1:8], cfg.max_backoff));
        phase_d   = PH_RETRYING;
        armed_d   = 1'b0;
        sl_d      = '0;
        rl_d      = delay_q;
        two_d     = 1'b0;
        res1_d    = make_result(PC_RETRYING, fault_q, 32'(delay_q), CMD_DISCONNECT, 1'b1);
        if (op_q == OP_TICK && delay_q == '0) begin
          phase_d            = PH_CONNECTING;
          sl_d               = cfg.startup_limit;
          armed_d            = 1'b1;
          rl_d               = '0;
          res1_d.last_result = 1'b0;
          res2_d = make_result(PC_CONNECTING, FAULT_NONE, '0, CMD_BOTH, 1'b1);
          two_d  = 1'b1;
        end
        state_d = S_OUT1;
      end

      S_OUT1: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res1_q;
          out_valid_d = 1'b1;
          state_d     = two_q ? S_OUT2 : S_IDLE;
        end
      end

      S_OUT2: begin
        if (!out_valid_q || out_o.ready) begin
          out_d       = res2_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: state_d = S_IDLE;
    endcase
  end

  // Hold state, supervisor registers and the output valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      phase_q     <= PH_STOPPED;
      backoff_q   <= INITIAL_BACKOFF_RST;
      sl_q        <= '0;
      armed_q     <= 1'b0;
      rl_q        <= '0;
      two_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      phase_q     <= phase_d;
      backoff_q   <= backoff_d;
      sl_q        <= sl_d;
      armed_q     <= armed_d;
      rl_q        <= rl_d;
      two_q       <= two_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q     <= op_d;
    r_q      <= r_d;
    reason_q <= reason_d;
    fault_q  <= fault_d;
    delay_q  <= delay_d;
    res1_q   <= res1_d;
    res2_q   <= res2_d;
    out_q    <= out_d;
  end

  assign in_i.ready         = (state_q == S_IDLE);
  assign out_o.valid        = out_valid_q;
  assign out_o.phase_code   = out_q.phase_code;
  assign out_o.fault_code   = out_q.fault_code;
  assign out_o.retry_delay  = out_q.retry_delay;
  assign out_o.link_command = out_q.link_command;
  assign out_o.last_result  = out_q.last_result;

endmodule
